@@ rtl/core/lzwc_pkg.sv @@
// Shared constants for the LZW compressor: register indexes, defaults and hash settings.
package lzwc_pkg;

  localparam int unsigned TableSlotsDef = 131072;
  localparam int unsigned CodeBitsDef   = 16;

  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 1;

  localparam logic [CfgIndexW-1:0] RegDictLimit = 1'b0;
  localparam logic [CfgIndexW-1:0] RegResetFull = 1'b1;

  localparam logic [15:0] DictLimitReset = 16'd65535;
  localparam logic        ResetFullReset = 1'b1;

  localparam int unsigned FirstFreeCode = 256;
  localparam int unsigned EpochBits     = 8;
  localparam logic [31:0] HashMult      = 32'h9E37_79B1;

endpackage

@@ rtl/core/lzw_compressor.sv @@
// LZW byte-stream compressor with a hashed dictionary in one synchronous memory.
//
// Input requests carry one byte and an end flag; output requests carry one code and
// a flag that marks the flushed final code of a stream. Both channels use valid and
// stall, and a request moves when valid is high and stall is low.
// The first byte of a stream only sets the prefix, unless it ends the stream. Every
// further byte passes a hash step and then probe steps, since each byte reads the
// dictionary memory once per probe through its single read port. A byte that emits
// a code passes an emit step that hands the codes to the two-entry output queue.
// A new byte is taken while earlier codes still wait in the output queue; the input
// stalls only while a byte is being worked on, including an emit step waiting for the
// queue to empty. After reset and every 255th dictionary clear, a sweep of all slots
// rewrites the memory tags, and input is stalled during it. Configuration writes
// belong between streams, while no byte is being worked on, and apply from the next byte.
// A receiver that stalls holds the head code; an emit step then waits for an empty queue.
module lzw_compressor
  import lzwc_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = TableSlotsDef,
  parameter int unsigned CODE_BITS   = CodeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [15:0]          code_o,
  output logic                 last_code_o
);

  localparam int unsigned AW    = $clog2(TABLE_SLOTS);
  localparam int unsigned KeyW  = CODE_BITS + 8;
  localparam int unsigned SlotW = EpochBits + KeyW + CODE_BITS;

  localparam logic [AW:0]   LastProbe = (AW+1)'(TABLE_SLOTS - 1);
  localparam logic [AW-1:0] LastAddr  = AW'(TABLE_SLOTS - 1);
  localparam logic [15:0]   CodeMax   = 16'((1 << CODE_BITS) - 1);
  localparam logic [CODE_BITS-1:0] FirstCode = CODE_BITS'(FirstFreeCode);
  localparam logic [EpochBits-1:0] EpochMax  = '1;
  localparam logic [EpochBits-1:0] EpochOne  = EpochBits'(1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [SlotW-1:0] mem [TABLE_SLOTS];
  logic [SlotW-1:0] rd_q;
  logic             mem_we, rd_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [SlotW-1:0] wr_data;

  logic [2:0]           state_q, state_d;
  logic [15:0]          dict_limit_q;
  logic                 reset_full_q;
  logic [CODE_BITS-1:0] prefix_q, prefix_d;
  logic                 present_q, present_d;
  logic [CODE_BITS-1:0] nfc_q, nfc_d;
  logic [EpochBits-1:0] epoch_q, epoch_d;
  logic                 sweep_q, sweep_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [7:0]           byte_q, byte_d;
  logic                 eod_q, eod_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [AW:0]          n_q, n_d;
  logic                 miss_q, miss_d;
  logic [CODE_BITS-1:0] emit_q, emit_d;

  logic [15:0] fcode_q [2];
  logic [15:0] fcode_d [2];
  logic [1:0]  flast_q, flast_d;
  logic [1:0]  cnt_q, cnt_d;

  logic [31:0]          prod;
  logic [15:0]          limit;
  logic [EpochBits-1:0] slot_ep;
  logic [KeyW-1:0]      slot_key;
  logic [CODE_BITS-1:0] slot_code;
  logic                 sweep_now;

  assign prod      = 32'(32'(key_q) * HashMult);
  assign limit     = (dict_limit_q > CodeMax) ? CodeMax : dict_limit_q;
  assign slot_ep   = rd_q[SlotW-1 -: EpochBits];
  assign slot_key  = rd_q[CODE_BITS +: KeyW];
  assign slot_code = rd_q[CODE_BITS-1:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (cnt_q != 2'd0);
  assign code_o      = fcode_q[0];
  assign last_code_o = flast_q[0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d   = state_q;
    prefix_d  = prefix_q;
    present_d = present_q;
    nfc_d     = nfc_q;
    epoch_d   = epoch_q;
    sweep_d   = sweep_q;
    clr_d     = clr_q;
    byte_d    = byte_q;
    eod_d     = eod_q;
    key_d     = key_q;
    pos_d     = pos_q;
    n_d       = n_q;
    miss_d    = miss_q;
    emit_d    = emit_q;
    fcode_d   = fcode_q;
    flast_d   = flast_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    wr_addr   = pos_q;
    wr_data   = {epoch_q, key_q, nfc_q};
    rd_en     = 1'b0;
    rd_addr   = prod[AW-1:0];
    sweep_now = sweep_q;

    if (cnt_q != 2'd0 && !out_stall_i) begin
      fcode_d[0] = fcode_q[1];
      flast_d[0] = flast_q[1];
      cnt_d      = cnt_q - 2'd1;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we  = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          epoch_d = EpochOne;
          sweep_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          byte_d = data_byte_i;
          eod_d  = end_of_data_i;
          miss_d = 1'b0;
          if (!present_q) begin
            prefix_d  = CODE_BITS'(data_byte_i);
            present_d = 1'b1;
            if (end_of_data_i) begin
              state_d = S_EMIT;
            end
          end else begin
            key_d   = {prefix_q, data_byte_i};
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        rd_en   = 1'b1;
        rd_addr = prod[AW-1:0];
        pos_d   = prod[AW-1:0];
        n_d     = '0;
        state_d = S_PROBE;
      end
      S_PROBE: begin
        if (slot_ep == epoch_q && slot_key == key_q) begin
          prefix_d = slot_code;
          state_d  = eod_q ? S_EMIT : S_IDLE;
        end else if (slot_ep != epoch_q || n_q == LastProbe) begin
          miss_d   = 1'b1;
          emit_d   = prefix_q;
          prefix_d = CODE_BITS'(byte_q);
          state_d  = S_EMIT;
          if (16'(nfc_q) < limit) begin
            if (slot_ep != epoch_q) begin
              mem_we  = 1'b1;
              wr_addr = pos_q;
              nfc_d   = nfc_q + CODE_BITS'(1);
            end
          end else if (reset_full_q) begin
            nfc_d = FirstCode;
            if (epoch_q == EpochMax) begin
              sweep_d = 1'b1;
            end else begin
              epoch_d = epoch_q + EpochOne;
            end
          end
        end else begin
          pos_d   = pos_q + AW'(1);
          n_d     = n_q + (AW+1)'(1);
          rd_en   = 1'b1;
          rd_addr = pos_q + AW'(1);
        end
      end
      S_EMIT: begin
        if (cnt_q == 2'd0) begin
          if (miss_q) begin
            fcode_d[0] = 16'(emit_q);
            flast_d[0] = 1'b0;
            fcode_d[1] = 16'(prefix_q);
            flast_d[1] = 1'b1;
            cnt_d      = eod_q ? 2'd2 : 2'd1;
          end else begin
            fcode_d[0] = 16'(prefix_q);
            flast_d[0] = 1'b1;
            cnt_d      = 2'd1;
          end
          if (eod_q) begin
            prefix_d  = '0;
            present_d = 1'b0;
            nfc_d     = FirstCode;
            if (epoch_q == EpochMax) begin
              sweep_now = 1'b1;
            end else begin
              epoch_d = epoch_q + EpochOne;
            end
          end
          if (sweep_now) begin
            clr_d   = '0;
            sweep_d = 1'b1;
            state_d = S_CLEAR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      dict_limit_q <= DictLimitReset;
      reset_full_q <= ResetFullReset;
      prefix_q     <= '0;
      present_q    <= 1'b0;
      nfc_q        <= FirstCode;
      epoch_q      <= EpochOne;
      sweep_q      <= 1'b0;
      clr_q        <= '0;
      miss_q       <= 1'b0;
      eod_q        <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      state_q   <= state_d;
      prefix_q  <= prefix_d;
      present_q <= present_d;
      nfc_q     <= nfc_d;
      epoch_q   <= epoch_d;
      sweep_q   <= sweep_d;
      clr_q     <= clr_d;
      miss_q    <= miss_d;
      eod_q     <= eod_d;
      cnt_q     <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegDictLimit: dict_limit_q <= cfg_data_i;
          RegResetFull: reset_full_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    key_q   <= key_d;
    pos_q   <= pos_d;
    n_q     <= n_d;
    emit_q  <= emit_d;
    fcode_q <= fcode_d;
    flast_q <= flast_d;
  end

  a_queue_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output queue holds more than two codes");

  a_nfc_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    16'(nfc_q) >= 16'(FirstFreeCode))
    else $error("next free code fell below the first dictionary code");

  a_lookup_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && present_q |=> state_q == S_HASH)
    else $error("byte with a live prefix did not start a lookup");

  a_emit_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && cnt_q == 2'd0 |=> cnt_q != 2'd0)
    else $error("emit step pushed no code");

endmodule

@@ verif/lzw_code_checker.sv @@
// Checker for the LZW compressor: predicts the emitted codes and compares them.
`timescale 1ns / 1ps
module lzw_code_checker
  import lzwc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 end_of_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [15:0]          code_i,
  input  logic                 last_code_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [15:0] code;
    logic        last;
  } code_item_t;

  code_item_t  pending_codes[$];
  int unsigned dict[int unsigned];
  logic [15:0] limit_q;
  logic        clear_when_full_q;
  logic [15:0] prefix_q;
  logic        have_prefix_q;
  int unsigned next_code_q;

  assign pending_o = pending_codes.size();

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic compress_byte(input logic [7:0] b, input logic eod);
    int unsigned key;
    if (!have_prefix_q) begin
      prefix_q      = {8'd0, b};
      have_prefix_q = 1'b1;
    end else begin
      key = 32'({prefix_q, b});
      if (dict.exists(key)) begin
        prefix_q = dict[key][15:0];
      end else begin
        pending_codes.push_back('{code: prefix_q, last: 1'b0});
        if (next_code_q < limit_q) begin
          dict[key] = next_code_q;
          next_code_q++;
        end else if (clear_when_full_q) begin
          dict.delete();
          next_code_q = FirstFreeCode;
        end
        prefix_q = {8'd0, b};
      end
    end
    if (eod) begin
      pending_codes.push_back('{code: prefix_q, last: 1'b1});
      prefix_q      = '0;
      have_prefix_q = 1'b0;
      dict.delete();
      next_code_q = FirstFreeCode;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    code_item_t exp_item;
    if (!rst_ni) begin
      limit_q           = DictLimitReset;
      clear_when_full_q = ResetFullReset;
      prefix_q          = '0;
      have_prefix_q     = 1'b0;
      next_code_q       = FirstFreeCode;
      dict.delete();
      pending_codes.delete();
      fail_count_o      = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegDictLimit) limit_q = cfg_data_i;
        else if (cfg_index_i == RegResetFull) clear_when_full_q = cfg_data_i[0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected code %0d last %0b", code_i, last_code_i));
        end else begin
          exp_item = pending_codes.pop_front();
          if (code_i !== exp_item.code)
            report_mismatch($sformatf("code %0d, expected %0d", code_i, exp_item.code));
          if (last_code_i !== exp_item.last)
            report_mismatch($sformatf("last_code %0b, expected %0b", last_code_i,
                                      exp_item.last));
        end
      end
      if (in_valid_i && !in_stall_i) compress_byte(data_byte_i, end_of_data_i);
    end
  end

endmodule

@@ verif/tb_lzw_compressor.sv @@
// Testbench top for the LZW compressor: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_lzw_compressor;
  import lzwc_pkg::*;

  localparam int unsigned WatchdogLimit = 600000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i;
  logic                 end_of_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [15:0]          code_o;
  logic                 last_code_o;
  logic                 in_taken;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles;

  lzw_compressor DUT (.*);

  lzw_code_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .data_byte_i, .end_of_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .code_i(code_o), .last_code_i(last_code_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_valid_i && !in_stall_o;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The receiver stalls at random, with one long hold-off so the block backs up.
  initial begin
    int unsigned steps;
    out_stall_i = 1'b0;
    steps = 0;
    @(posedge rst_ni);
    wait (!in_stall_o);
    forever begin
      @(negedge clk_i);
      steps++;
      if (steps == 1000) begin
        out_stall_i = 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else if (steps % 1500 < 300) begin
        out_stall_i = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat (gap_len()) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    in_valid_i    = 1'b1;
    data_byte_i   = b;
    end_of_data_i = eod;
    do @(negedge clk_i); while (!in_taken);
    in_valid_i = 1'b0;
    repeat (gap_len()) @(negedge clk_i);
  endtask

  task automatic send_stream(input int unsigned len, input int unsigned alphabet);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if (alphabet == 0 || $urandom_range(0, 15) == 0) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(0, alphabet - 1));
      send_byte(b, i == len - 1);
    end
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [15:0] value);
    wait (pending == 0);
    @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] limit, input logic clear_full,
                           input int unsigned items);
    int unsigned sent;
    int unsigned len;
    write_reg(RegDictLimit, limit);
    write_reg(RegResetFull, {15'd0, clear_full});
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      send_stream(len, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 5));
      sent += len;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = RegDictLimit;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    end_of_data_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b1);
    send_byte(8'd65, 1'b0);
    send_byte(8'd66, 1'b1);
    for (int i = 0; i < 8; i++) send_byte(8'd97, i == 7);
    send_byte(8'd1, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'd2, 1'b0);
    send_byte(8'd170, 1'b0);
    send_byte(8'd85, 1'b1);

    run_phase(16'd65535, 1'b1, 80);
    run_phase(16'd257, 1'b1, 50);
    run_phase(16'd257, 1'b0, 50);
    run_phase(16'd260, 1'b1, 60);
    run_phase(16'd270, 1'b0, 60);
    run_phase(16'd100, 1'b1, 30);
    run_phase(16'd256, 1'b0, 30);
    run_phase(16'd300, 1'b1, 70);
    run_phase(16'd65535, 1'b0, 50);

    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ lzw_compressor.f @@
rtl/core/lzwc_pkg.sv
rtl/core/lzw_compressor.sv
verif/lzw_code_checker.sv
verif/tb_lzw_compressor.sv
